/* design/ssvg_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the smeared step volume and gauss potential core
// no dependencies

package ssvg_pkg;

  localparam logic [1:0] OP_SAMPLE     = 2'd0;
  localparam logic [1:0] OP_LOAD_STEP  = 2'd1;
  localparam logic [1:0] OP_LOAD_GAUSS = 2'd2;

  localparam logic [2:0] CFG_LOWER_EDGE   = 3'd0;
  localparam logic [2:0] CFG_CENTER       = 3'd1;
  localparam logic [2:0] CFG_STEP_INVERSE = 3'd2;
  localparam logic [2:0] CFG_GAUSS_INDEX  = 3'd3;
  localparam logic [2:0] CFG_GAUSS_SCALE  = 3'd4;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_STEP,
    KIND_GAUSS
  } kind_e;

  typedef struct packed {
    logic [31:0] lower_edge;
    logic [31:0] center_density;
    logic [31:0] step_inverse;
    logic [31:0] gauss_index_scale;
    logic [31:0] gauss_scale;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic        above;
    logic [31:0] offset;
    logic [31:0] magnitude;
    logic [31:0] potential_in;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
    logic        last_point;
  } item_t;

endpackage

/* design/smeared_step_volume_and_gauss_potential_core.sv */
`timescale 1ns / 1ps
// Streams density samples and table loads. Each sample adds an interpolated smeared
// step value to a saturating Q32.16 volume sum and a table-driven Gaussian term to the
// potential. A front end decodes each transfer and computes the density offsets, then
// hands it through a two-entry queue to a back-end sequencer. A sample passes its
// states in order (dequeue, two 32x32 index multiplies, registered table reads,
// interpolation and gain products, result) and no new item is taken until its result
// is written; a table load is written at dequeue. The result register frees the
// sequencer once its value is taken. Tables are undefined until loaded; the
// accumulator clears at reset and after a last sample. Configuration is registered.
// depends on ssvg_pkg, ssvg_front, ssvg_fifo, ssvg_back

module smeared_step_volume_and_gauss_potential_core
  import ssvg_pkg::*;
#(
  parameter int STEP_POINTS  = 256,
  parameter int GAUSS_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] density_i,
  input  logic [31:0] potential_in_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] potential_out_o,
  output logic [47:0] volume_sum_o,
  output logic        last_point_out_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push_valid, push_ready;
  item_t push_data;
  logic  pop_valid, pop_ready;
  item_t pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOWER_EDGE:   cfg_d.lower_edge        = cfg_data_i;
        CFG_CENTER:       cfg_d.center_density    = cfg_data_i;
        CFG_STEP_INVERSE: cfg_d.step_inverse      = cfg_data_i;
        CFG_GAUSS_INDEX:  cfg_d.gauss_index_scale = cfg_data_i;
        CFG_GAUSS_SCALE:  cfg_d.gauss_scale       = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_edge        <= 32'd0;
      cfg_q.center_density    <= 32'd0;
      cfg_q.step_inverse      <= 32'd65536;
      cfg_q.gauss_index_scale <= 32'd65536;
      cfg_q.gauss_scale       <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssvg_front u_front (
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .density_i     (density_i),
    .potential_in_i(potential_in_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .last_point_i  (last_point_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  ssvg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  ssvg_back #(
    .STEP_POINTS (STEP_POINTS),
    .GAUSS_POINTS(GAUSS_POINTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .potential_out_o (potential_out_o),
    .volume_sum_o    (volume_sum_o),
    .last_point_out_o(last_point_out_o)
  );

endmodule

/* design/ssvg_front.sv */
`timescale 1ns / 1ps
// front end: input handshake, operation decode and density offsets
// depends on ssvg_pkg

module ssvg_front
  import ssvg_pkg::*;
(
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] density_i,
  input  logic [31:0] potential_in_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  input  logic        last_point_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output item_t       push_data_o
);

  logic        known_op;
  kind_e       kind;
  logic [32:0] delta;
  logic [32:0] delta_abs;

  always_comb begin
    known_op = 1'b1;
    kind     = KIND_SAMPLE;
    case (operation_i)
      OP_SAMPLE:     kind = KIND_SAMPLE;
      OP_LOAD_STEP:  kind = KIND_STEP;
      OP_LOAD_GAUSS: kind = KIND_GAUSS;
      default:       known_op = 1'b0;
    endcase
  end

  assign delta     = {density_i[31], density_i}
                   - {cfg_i.center_density[31], cfg_i.center_density};
  assign delta_abs = delta[32] ? (33'd0 - delta) : delta;

  // unused operation codes are taken and dropped
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && known_op;

  always_comb begin
    push_data_o.kind         = kind;
    push_data_o.above        = $signed(density_i) > $signed(cfg_i.lower_edge);
    push_data_o.offset       = density_i - cfg_i.lower_edge;
    push_data_o.magnitude    = delta_abs[31:0];
    push_data_o.potential_in = potential_in_i;
    push_data_o.entry_index  = entry_index_i;
    push_data_o.entry_value  = entry_value_i;
    push_data_o.last_point   = last_point_i;
  end

endmodule

/* design/ssvg_fifo.sv */
`timescale 1ns / 1ps
// two-entry queue between front and back ends
// depends on ssvg_pkg

module ssvg_fifo
  import ssvg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_data_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/ssvg_back.sv */
`timescale 1ns / 1ps
// back end: table memories, step interpolation, gaussian term, volume accumulator
// depends on ssvg_pkg

module ssvg_back
  import ssvg_pkg::*;
#(
  parameter int STEP_POINTS  = 256,
  parameter int GAUSS_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  item_t       pop_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] potential_out_o,
  output logic [47:0] volume_sum_o,
  output logic        last_point_out_o
);

  localparam int StepAw  = $clog2(STEP_POINTS);
  localparam int GaussAw = $clog2(GAUSS_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_READ,
    ST_PROD,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic [47:0] acc_q, acc_d;

  logic [15:0] step_mem [STEP_POINTS];
  logic [15:0] gauss_mem [GAUSS_POINTS];

  item_t              item_q;
  logic [63:0]        step_pos_q;
  logic [63:0]        gauss_pos_q;
  logic               step_full_q;
  logic               gauss_zero_q;
  logic [15:0]        frac_q;
  logic [15:0]        t0_q, t1_q, gt_q;
  logic [32:0]        prod0_q;
  logic [31:0]        prod1_q;
  logic signed [47:0] gprod_q;
  logic [31:0]        potential_q;
  logic [47:0]        volume_q;
  logic               last_q;

  logic               pop;
  logic               step_we, gauss_we;
  logic               out_free;
  logic [63:0]        step_pos_d;
  logic [63:0]        gauss_pos_d;
  logic [23:0]        step_idx;
  logic [23:0]        gauss_idx;
  logic [StepAw-1:0]  rd0_addr, rd1_addr;
  logic [GaussAw-1:0] gauss_addr;
  logic [32:0]        prod0_d;
  logic [31:0]        prod1_d;
  logic signed [47:0] gprod_d;
  logic [33:0]        interp_sum;
  logic [16:0]        step_val;
  logic [48:0]        vol_sum;
  logic [47:0]        vol_sat;
  logic signed [31:0] gauss_term;
  logic signed [32:0] pot_sum;
  logic [31:0]        pot_sat;

  assign pop         = (state_q == ST_IDLE) && pop_valid_i;
  assign pop_ready_o = state_q == ST_IDLE;
  assign out_free    = !out_valid_q || out_ready_i;

  assign step_we  = pop && (pop_data_i.kind == KIND_STEP)
                 && (32'(pop_data_i.entry_index) < 32'(STEP_POINTS));
  assign gauss_we = pop && (pop_data_i.kind == KIND_GAUSS)
                 && (32'(pop_data_i.entry_index) < 32'(GAUSS_POINTS));

  assign step_pos_d  = item_q.offset * cfg_i.step_inverse;
  assign gauss_pos_d = item_q.magnitude * cfg_i.gauss_index_scale;

  assign step_idx   = step_pos_q[63:40];
  assign gauss_idx  = gauss_pos_q[63:40];
  assign rd0_addr   = StepAw'(step_idx);
  assign rd1_addr   = rd0_addr + StepAw'(1);
  assign gauss_addr = GaussAw'(gauss_idx);

  assign prod0_d = t0_q * (ONE_Q16 - {1'b0, frac_q});
  assign prod1_d = t1_q * frac_q;
  assign gprod_d = $signed(cfg_i.gauss_scale) * $signed({1'b0, gt_q});

  assign interp_sum = {1'b0, prod0_q} + {2'b0, prod1_q};
  assign step_val   = step_full_q ? ONE_Q16 : interp_sum[32:16];
  assign vol_sum    = {1'b0, acc_q} + (item_q.above ? 49'(step_val) : 49'd0);
  assign vol_sat    = vol_sum[48] ? {48{1'b1}} : vol_sum[47:0];

  // floor shift of the gain product
  assign gauss_term = gauss_zero_q ? 32'sd0 : gprod_q[47:16];
  assign pot_sum    = $signed({item_q.potential_in[31], item_q.potential_in})
                    + $signed({gauss_term[31], gauss_term});
  always_comb begin
    if (pot_sum[32] != pot_sum[31]) begin
      pot_sat = pot_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      pot_sat = pot_sum[31:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    case (state_q)
      ST_IDLE: begin
        if (pop && (pop_data_i.kind == KIND_SAMPLE)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_READ;
      ST_READ: state_d = ST_PROD;
      ST_PROD: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          acc_d       = item_q.last_point ? 48'd0 : vol_sat;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= 48'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= pop_data_i;
    end
    if (state_q == ST_MUL) begin
      step_pos_q  <= step_pos_d;
      gauss_pos_q <= gauss_pos_d;
    end
    if (state_q == ST_READ) begin
      step_full_q  <= step_idx >= 24'(STEP_POINTS - 1);
      gauss_zero_q <= gauss_idx >= 24'(GAUSS_POINTS);
      frac_q       <= step_pos_q[39:24];
    end
    if (state_q == ST_PROD) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
      gprod_q <= gprod_d;
    end
    if ((state_q == ST_DONE) && out_free) begin
      potential_q <= pot_sat;
      volume_q    <= vol_sat;
      last_q      <= item_q.last_point;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_we) begin
      step_mem[StepAw'(pop_data_i.entry_index)] <= pop_data_i.entry_value;
    end
    if (state_q == ST_READ) begin
      t0_q <= step_mem[rd0_addr];
      t1_q <= step_mem[rd1_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gauss_we) begin
      gauss_mem[GaussAw'(pop_data_i.entry_index)] <= pop_data_i.entry_value;
    end
    if (state_q == ST_READ) begin
      gt_q <= gauss_mem[gauss_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign potential_out_o  = potential_q;
  assign volume_sum_o     = volume_q;
  assign last_point_out_o = last_q;

endmodule
